>>> rtl/ctgq_pkg.sv
// shared types and constants for the credit gated transmit queue
// depends on nothing; imported by ctgq_front, ctgq_back and the top level
package ctgq_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned CREDIT_W = 16;
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned QLEN_W   = 9;
  localparam int unsigned DROP_W   = 32;
  localparam int unsigned LIMIT_W  = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  // input commands
  localparam logic [CMD_W-1:0] CMD_DATA     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FEEDBACK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

  // result actions
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SENT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_NOTICE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DROP   = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [TAG_W-1:0]    packet_tag;
    logic [CREDIT_W-1:0] credit_value;
  } ctgq_in_t;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [TAG_W-1:0]    sent_tag;
    logic [QLEN_W-1:0]   queue_length;
    logic [CREDIT_W-1:0] credit_now;
    logic [DROP_W-1:0]   drop_total;
  } ctgq_out_t;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_CREDIT,
    OP_TICK,
    OP_NONE
  } ctgq_op_kind_e;

  // classified operation passed from front to back
  typedef struct packed {
    ctgq_op_kind_e       kind;
    logic [TAG_W-1:0]    tag;
    logic [CREDIT_W-1:0] credit;
  } ctgq_op_t;

endpackage

>>> rtl/ctgq_front.sv
// front end: accepts input transactions, classifies the command and buffers
// the classified operation in a two-entry queue; depends on ctgq_pkg
module ctgq_front import ctgq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ctgq_in_t item_i,
  output logic     full_o,
  output logic     op_valid_o,
  output ctgq_op_t op_o,
  input  logic     op_ready_i
);

  localparam int unsigned SLOTS = 2;

  ctgq_op_t   slot_q [SLOTS];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;
  ctgq_op_t   op_new;

  // decode the raw command
  always_comb begin
    op_new.tag    = item_i.packet_tag;
    op_new.credit = item_i.credit_value;
    case (item_i.command)
      CMD_DATA:     op_new.kind = OP_ENQ;
      CMD_FEEDBACK: op_new.kind = OP_CREDIT;
      CMD_TICK:     op_new.kind = OP_TICK;
      default:      op_new.kind = OP_NONE;
    endcase
  end

  assign full_o     = (count_q == 2'(SLOTS));
  assign op_valid_o = (count_q != 2'd0);
  assign op_o       = slot_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = op_valid_o && op_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= op_new;
    end
  end

  // the buffer never holds more than its two slots
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(SLOTS))
    else $error("front buffer count out of range");

endmodule

>>> rtl/ctgq_back.sv
// back end: executes classified operations against the tag store, credit and
// drop counter, and holds one result transaction; depends on ctgq_pkg
module ctgq_back import ctgq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i,
  input  logic               op_valid_i,
  input  ctgq_op_t           op_i,
  output logic               op_ready_o,
  output logic               res_empty_o,
  input  logic               res_pop_i,
  output ctgq_out_t          result_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (OCC_W > LIMIT_W) ? OCC_W : LIMIT_W;

  logic [TAG_W-1:0]    tag_mem [QUEUE_DEPTH];
  logic [TAG_W-1:0]    rd_tag_q;
  logic [IDX_W-1:0]    head_q, head_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [OCC_W-1:0]    occ_q, occ_d;
  logic [CREDIT_W-1:0] credit_q, credit_d;
  logic [DROP_W-1:0]   drop_q, drop_d;
  logic [LIMIT_W-1:0]  limit_q;
  logic                res_valid_q;
  ctgq_out_t           res_q;
  logic [ACT_W-1:0]    act;
  logic                fire, wr_en, rd_en, at_limit;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  assign op_ready_o  = !res_valid_q || res_pop_i;
  assign fire        = op_valid_i && op_ready_o;
  assign res_empty_o = !res_valid_q;

  assign at_limit = (CMP_W'(occ_q) >= CMP_W'(limit_q)) ||
                    (occ_q == OCC_W'(QUEUE_DEPTH));

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    credit_d = credit_q;
    drop_d   = drop_q;
    act      = ACT_NONE;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    if (fire) begin
      case (op_i.kind)
        OP_ENQ: begin
          if (at_limit) begin
            if (drop_q != '1) begin
              drop_d = drop_q + DROP_W'(1);
            end
            act = ACT_DROP;
          end else begin
            wr_en  = 1'b1;
            tail_d = next_idx(tail_q);
            occ_d  = occ_q + OCC_W'(1);
          end
        end
        OP_CREDIT: begin
          credit_d = op_i.credit;
        end
        OP_TICK: begin
          if (occ_q != '0) begin
            if (credit_q == '0) begin
              act = ACT_NOTICE;
            end else begin
              rd_en    = 1'b1;
              head_d   = next_idx(head_q);
              occ_d    = occ_q - OCC_W'(1);
              credit_d = credit_q - CREDIT_W'(1);
              act      = ACT_SENT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      credit_q    <= '0;
      drop_q      <= '0;
      limit_q     <= LIMIT_RESET;
      res_valid_q <= 1'b0;
    end else begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      occ_q    <= occ_d;
      credit_q <= credit_d;
      drop_q   <= drop_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (fire) begin
        res_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result payload, sent tag joins from the store read register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q.action       <= act;
      res_q.sent_tag     <= '0;
      res_q.queue_length <= QLEN_W'(occ_d);
      res_q.credit_now   <= credit_d;
      res_q.drop_total   <= drop_d;
    end
  end

  // tag store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tag_mem[tail_q] <= op_i.tag;
    end
    if (rd_en) begin
      rd_tag_q <= tag_mem[head_q];
    end
  end

  always_comb begin
    result_o = res_q;
    if (res_q.action == ACT_SENT) begin
      result_o.sent_tag = rd_tag_q;
    end
  end

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> (head_q == tail_q))
    else $error("empty queue with head and tail apart");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  a_notice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && op_i.kind == OP_TICK && occ_q != '0 && credit_q == '0)
      |=> (res_valid_q && res_q.action == ACT_NOTICE && $stable(credit_q)))
    else $error("tick without credit did not give a window-full notice");

  a_drop_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drop_q >= $past(drop_q))
    else $error("drop counter went down");

endmodule

>>> rtl/credit_gated_tx_queue_unit.sv
// top level of the credit gated transmit queue
// depends on ctgq_pkg, ctgq_front and ctgq_back
//
//   channel   direction  handshake               payload
//   input     in         push / full             item_i   (ctgq_in_t)
//   result    out        empty / pop             result_o (ctgq_out_t)
//   config    in         cfg_we_i, no wait       cfg_wdata_i (queue limit)
//
// one transaction per cycle sustained while results are popped: every command,
// including a send, completes in the back end as it is accepted, the tag store read data is
// registered together with the result
// a pushed item is registered in the front buffer and then in the back end result register
// reset clears pointers, occupancy, credit and drop count, limit goes to 256;
// the tag store is not cleared, only written entries are ever read
// a stalled result holds the back end, the two-entry front buffer keeps
// accepting until it fills and raises full
module credit_gated_tx_queue_unit import ctgq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  ctgq_in_t           item_i,
  output logic               empty,
  input  logic               pop,
  output ctgq_out_t          result_o,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);

  // classified operations between front and back
  logic     op_valid;
  logic     op_ready;
  ctgq_op_t op;

  // front end: command decode and decoupling buffer
  ctgq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_ready_i (op_ready)
  );

  // back end: queue state, credit, drop count and the result register
  ctgq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_valid_i  (op_valid),
    .op_i        (op),
    .op_ready_o  (op_ready),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .result_o    (result_o)
  );

endmodule

>>> verif/credit_gated_tx_queue_unit_tb.sv
// self-checking testbench for credit_gated_tx_queue_unit: a shadow of the queue,
// credit and drop counter predicts every result transaction under random stalls
// depends on ctgq_pkg and the rtl of credit_gated_tx_queue_unit
module credit_gated_tx_queue_unit_tb;
  import ctgq_pkg::*;

  localparam int unsigned TAG_DEPTH   = 256;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // shadow of the transmit queue: tags, credit, drops and limit, plus the
  // results it has predicted but not yet seen
  class tx_queue_shadow;
    logic [TAG_W-1:0]    tags[$];
    logic [CREDIT_W-1:0] credit;
    logic [DROP_W-1:0]   drops;
    logic [LIMIT_W-1:0]  limit;
    ctgq_out_t           awaited[$];
    int                  errors;

    function new();
      credit = '0;
      drops  = '0;
      limit  = LIMIT_RESET;
      errors = 0;
    endfunction

    // predict the result of one accepted input transaction
    function void note_arrival(ctgq_in_t it);
      ctgq_out_t r;
      r        = '0;
      r.action = ACT_NONE;
      case (it.command)
        CMD_DATA: begin
          if (tags.size() >= int'(limit) || tags.size() >= TAG_DEPTH) begin
            if (drops != '1) drops++;
            r.action = ACT_DROP;
          end else begin
            tags.push_back(it.packet_tag);
          end
        end
        CMD_FEEDBACK: credit = it.credit_value;
        CMD_TICK: begin
          if (tags.size() != 0) begin
            if (credit == '0) begin
              r.action = ACT_NOTICE;
            end else begin
              r.sent_tag = tags.pop_front();
              credit--;
              r.action = ACT_SENT;
            end
          end
        end
        default: ;
      endcase
      r.queue_length = QLEN_W'(tags.size());
      r.credit_now   = credit;
      r.drop_total   = drops;
      awaited.push_back(r);
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_report(ctgq_out_t got);
      ctgq_out_t want;
      if (awaited.size() == 0) begin
        $error("result with nothing awaited: action %0d tag %0d", got.action, got.sent_tag);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.action !== want.action) begin
        $error("action expected %0d actual %0d", want.action, got.action);
        errors++;
      end
      if (got.sent_tag !== want.sent_tag) begin
        $error("sent_tag expected %0d actual %0d", want.sent_tag, got.sent_tag);
        errors++;
      end
      if (got.queue_length !== want.queue_length) begin
        $error("queue_length expected %0d actual %0d", want.queue_length, got.queue_length);
        errors++;
      end
      if (got.credit_now !== want.credit_now) begin
        $error("credit_now expected %0d actual %0d", want.credit_now, got.credit_now);
        errors++;
      end
      if (got.drop_total !== want.drop_total) begin
        $error("drop_total expected %0d actual %0d", want.drop_total, got.drop_total);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               push;
  logic               full;
  ctgq_in_t           item_i;
  logic               empty;
  logic               pop;
  ctgq_out_t          result_o;
  logic               cfg_we_i;
  logic [LIMIT_W-1:0] cfg_wdata_i;

  tx_queue_shadow shadow;

  // stall control: steady is shared by the sender and the receiver, the hold-off is the receiver's
  bit          steady;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned cycle_count;

  // coverage tallies for the closing summary
  int unsigned n_in, n_sent, n_notice, n_drop, n_limits, n_full_seen;

  credit_gated_tx_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("credit_gated_tx_queue_unit_tb: errors");
      $finish;
    end
  end

  // monitor: both handshakes sampled at the edge, before the driven values move
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      shadow.note_arrival(item_i);
      n_in++;
    end
    if (rst_ni && push && full) n_full_seen++;
    if (rst_ni && pop && !empty) begin
      case (result_o.action)
        ACT_SENT:   n_sent++;
        ACT_NOTICE: n_notice++;
        ACT_DROP:   n_drop++;
        default: ;
      endcase
      shadow.check_report(result_o);
    end
  end

  // receiver: random pops, plus a long counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (!steady && $urandom_range(99) < 20) begin
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // offer one input transaction and wait until it is taken
  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [TAG_W-1:0] tag,
                          logic [CREDIT_W-1:0] cval);
    ctgq_in_t it;
    it.command      = cmd;
    it.packet_tag   = tag;
    it.credit_value = cval;
    if (!steady && $urandom_range(99) < 20) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push   <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (full);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain_results();
    push <= 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // limit register write, only while the block is idle
  task automatic write_limit(logic [LIMIT_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    shadow.limit  = value;
    n_limits++;
    @(posedge clk_i);
  endtask

  // random traffic: mostly data and ticks with small credit so that the
  // queue both fills and hits a closed window, some feedback and unused codes
  task automatic run_random(int unsigned count, int unsigned data_pct, int unsigned tick_pct);
    int unsigned         r;
    logic [CMD_W-1:0]    cmd;
    logic [CREDIT_W-1:0] cval;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < data_pct) cmd = CMD_DATA;
      else if (r < data_pct + tick_pct) cmd = CMD_TICK;
      else if ($urandom_range(99) < 85) cmd = CMD_FEEDBACK;
      else cmd = ~CMD_DATA;
      if ($urandom_range(99) < 70) cval = CREDIT_W'($urandom_range(0, 4));
      else cval = CREDIT_W'($urandom);
      send_cmd(cmd, TAG_W'($urandom), cval);
    end
  endtask

  initial begin
    shadow       = new();
    steady       = 1'b0;
    hold_request = 0;
    hold_left    = 0;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    item_i      <= '0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tick, unused code, tag extremes, closed window, send
    send_cmd(CMD_TICK, 16'h0000, 16'h0000);
    send_cmd(~CMD_DATA, 16'hffff, 16'hffff);
    send_cmd(CMD_DATA, 16'h0000, 16'hffff);
    send_cmd(CMD_DATA, 16'hffff, 16'h0000);
    send_cmd(CMD_TICK, 16'hffff, 16'hffff);
    send_cmd(CMD_FEEDBACK, 16'hffff, 16'h0001);
    send_cmd(CMD_TICK, 16'h0000, 16'h0000);
    send_cmd(CMD_TICK, 16'h0000, 16'h0000);
    send_cmd(CMD_FEEDBACK, 16'h0000, 16'hffff);
    send_cmd(CMD_TICK, 16'h0000, 16'h0000);
    send_cmd(CMD_TICK, 16'h0000, 16'h0000);
    send_cmd(CMD_FEEDBACK, 16'h0000, 16'h0000);
    drain_results();

    // zero limit drops every arrival
    write_limit(9'd0);
    send_cmd(CMD_DATA, 16'h1234, 16'h0000);
    send_cmd(CMD_DATA, 16'hedcb, 16'hffff);
    send_cmd(CMD_TICK, 16'h0000, 16'h0000);
    drain_results();

    // limit of one
    write_limit(9'd1);
    send_cmd(CMD_DATA, 16'ha5a5, 16'h0000);
    send_cmd(CMD_DATA, 16'h5a5a, 16'h0000);
    send_cmd(CMD_FEEDBACK, 16'h0000, 16'h0003);
    send_cmd(CMD_TICK, 16'h0000, 16'h0000);
    send_cmd(CMD_TICK, 16'h0000, 16'h0000);
    drain_results();

    // limit above depth: fill past the store size with no idling at all,
    // then drain the whole queue through the credit window
    write_limit(9'd511);
    steady = 1'b1;
    send_cmd(CMD_FEEDBACK, 16'h0000, 16'h0000);
    repeat (TAG_DEPTH + 3) send_cmd(CMD_DATA, TAG_W'($urandom), CREDIT_W'($urandom));
    send_cmd(CMD_TICK, 16'h0000, 16'h0000);
    send_cmd(CMD_FEEDBACK, 16'h0000, 16'hffff);
    repeat (TAG_DEPTH + 2) send_cmd(CMD_TICK, TAG_W'($urandom), CREDIT_W'($urandom));
    steady = 1'b0;
    drain_results();

    // random phases across several limits
    write_limit(LIMIT_RESET);
    run_random(150, 45, 40);
    drain_results();

    // receiver holds off for a long stretch while items keep coming
    write_limit(9'd4);
    hold_request = 400;
    run_random(150, 45, 40);
    drain_results();

    write_limit(9'd300);
    run_random(150, 60, 25);
    drain_results();

    write_limit(9'd1);
    run_random(120, 45, 40);
    drain_results();

    write_limit(9'($urandom_range(2, 16)));
    run_random(150, 50, 35);
    drain_results();

    write_limit(9'd0);
    run_random(80, 45, 40);
    drain_results();

    write_limit(9'd511);
    run_random(150, 60, 25);
    drain_results();

    write_limit(LIMIT_RESET);
    run_random(150, 45, 40);
    drain_results();
    repeat (10) @(posedge clk_i);

    $display("covered %0d transactions over %0d limit settings, input stalled %0d cycles",
             n_in, n_limits, n_full_seen);
    $display("results: %0d sent, %0d window-full notices, %0d drops",
             n_sent, n_notice, n_drop);
    if (shadow.errors == 0) begin
      $display("credit_gated_tx_queue_unit_tb: clean");
    end else begin
      $display("credit_gated_tx_queue_unit_tb: errors");
    end
    $finish;
  end

endmodule
